>>> rtl/core/ssirq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted start index range query package
// Shared widths, operation and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package ssirq_pkg;

   localparam int TableDepthDefault = 256;
   localparam int MaxHitsDefault    = 1024;
   localparam int PosWidthDefault   = 16;

   localparam int OpWidth     = 2;
   localparam int FieldWidth  = 16;
   localparam int IndexWidth  = 8;
   localparam int PosOutWidth = 9;
   localparam int HitOutWidth = 10;
   localparam int StatusWidth = 2;

   localparam logic [OpWidth-1:0] OP_CLEAR = 2'd0;
   localparam logic [OpWidth-1:0] OP_ADD   = 2'd1;
   localparam logic [OpWidth-1:0] OP_QUERY = 2'd2;
   localparam logic [OpWidth-1:0] OP_READ  = 2'd3;

   localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] ST_FULL      = 2'd1;
   localparam logic [StatusWidth-1:0] ST_BAD_INDEX = 2'd2;
   localparam logic [StatusWidth-1:0] ST_EXHAUSTED = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request and initialize a search
      logic search_step; // issue/consume one probe
      logic search_lo;   // restart search with the low key
      logic shift_step;  // move one entry up by one
      logic insert;      // write the new entry at its place
      logic finish;      // form the response
   } ssirq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_done;
      logic shift_done;
      logic needs_insert;
   } ssirq_sts_type;

endpackage

>>> rtl/core/ssirq_req_if.sv
// ----------------------------------------------------------------------------
// Request and response channel interfaces
// Valid/ready handshakes with the query unit's request and response payloads.
// ----------------------------------------------------------------------------
interface ssirq_req_if;
   logic                             valid;
   logic                             ready;
   logic [ssirq_pkg::OpWidth-1:0]    operation;
   logic [ssirq_pkg::FieldWidth-1:0] start_pos;
   logic [ssirq_pkg::FieldWidth-1:0] stop_pos;
   logic                             is_discontiguous;
   logic [ssirq_pkg::IndexWidth-1:0] entry_index;

   modport source (output valid, operation, start_pos, stop_pos, is_discontiguous,
                   entry_index, input ready);
   modport sink (input valid, operation, start_pos, stop_pos, is_discontiguous,
                 entry_index, output ready);
endinterface

interface ssirq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ssirq_pkg::PosOutWidth-1:0] range_begin;
   logic [ssirq_pkg::PosOutWidth-1:0] range_end;
   logic [ssirq_pkg::HitOutWidth-1:0] entry_hit_number;
   logic [ssirq_pkg::FieldWidth-1:0]  entry_start;
   logic [ssirq_pkg::PosOutWidth-1:0] entry_count;
   logic [ssirq_pkg::StatusWidth-1:0] status;

   modport source (output valid, range_begin, range_end, entry_hit_number,
                   entry_start, entry_count, status, input ready);
   modport sink (input valid, range_begin, range_end, entry_hit_number,
                 entry_start, entry_count, status, output ready);
endinterface

>>> rtl/core/ssirq_ctrl.sv
// ----------------------------------------------------------------------------
// Query unit controller
// Sequences the searches, the entry shift and the response handshake.
// ----------------------------------------------------------------------------
module ssirq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_fire,
   input  logic [1:0]               req_op,
   input  logic                     rsp_taken,
   input  ssirq_pkg::ssirq_sts_type sts,
   output ssirq_pkg::ssirq_cmd_type cmd,
   output logic                     busy,
   output logic                     rsp_valid
);
   import ssirq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SRCH_H = 3'd1;
   localparam logic [2:0] S_SRCH_L = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_INSERT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_CLEAR;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               op_in    = req_op;
               // Both add and query start with the upper-bound search.
               if (req_op == OP_ADD || req_op == OP_QUERY) state_in = S_SRCH_H;
               else state_in = S_DONE;
            end
         end
         S_SRCH_H: begin
            if (sts.search_done) begin
               if (op_ff == OP_QUERY) begin
                  cmd.search_lo = 1'b1;
                  state_in = S_SRCH_L;
               end else if (sts.needs_insert) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_SRCH_L: begin
            if (sts.search_done) state_in = S_DONE;
            else cmd.search_step = 1'b1;
         end
         S_SHIFT: begin
            if (sts.shift_done) state_in = S_INSERT;
            else cmd.shift_step = 1'b1;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (rsp_taken) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

>>> rtl/core/ssirq_dp.sv
// ----------------------------------------------------------------------------
// Query unit datapath
// Entry tables, binary search, shift-insert and response registers.
// ----------------------------------------------------------------------------
module ssirq_dp #(
   parameter int TABLE_DEPTH = ssirq_pkg::TableDepthDefault,
   parameter int MAX_HITS    = ssirq_pkg::MaxHitsDefault,
   parameter int POS_WIDTH   = ssirq_pkg::PosWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ssirq_pkg::ssirq_cmd_type            cmd,
   output ssirq_pkg::ssirq_sts_type            sts,
   input  logic [ssirq_pkg::OpWidth-1:0]       req_operation,
   input  logic [ssirq_pkg::FieldWidth-1:0]    req_start_pos,
   input  logic [ssirq_pkg::FieldWidth-1:0]    req_stop_pos,
   input  logic                                req_is_discontiguous,
   input  logic [ssirq_pkg::IndexWidth-1:0]    req_entry_index,
   output logic [ssirq_pkg::PosOutWidth-1:0]   rsp_range_begin,
   output logic [ssirq_pkg::PosOutWidth-1:0]   rsp_range_end,
   output logic [ssirq_pkg::HitOutWidth-1:0]   rsp_entry_hit_number,
   output logic [ssirq_pkg::FieldWidth-1:0]    rsp_entry_start,
   output logic [ssirq_pkg::PosOutWidth-1:0]   rsp_entry_count,
   output logic [ssirq_pkg::StatusWidth-1:0]   rsp_status
);
   import ssirq_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int HW = $clog2(MAX_HITS);
   localparam int NW = $clog2(MAX_HITS + 1);
   localparam int IW = (CW > IndexWidth) ? CW : IndexWidth;

   logic [POS_WIDTH-1:0] start_mem [TABLE_DEPTH];
   logic [HW-1:0]        hit_mem   [TABLE_DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] next_hit_ff, next_hit_in;

   logic [1:0]           op_ff;
   logic [POS_WIDTH-1:0] lo_key_ff, key_ff;
   logic                 strict_ff; // 1: upper-bound search (<=), 0: lower bound
   logic                 disc_ff;
   logic [IndexWidth-1:0] idx_ff;
   logic [CW-1:0]        lo_ff, hi_ff, upper_ff, k_ff;
   logic                 pend_ff;   // a probe read is in flight
   logic                 full_ff, exh_ff;
   logic [HW-1:0]        hn_ff;

   logic [POS_WIDTH-1:0] rd_start_ff;
   logic [HW-1:0]        rd_hit_ff;
   logic [CW-1:0]        mid;
   logic                 go_right;

   logic [PosOutWidth-1:0] o_rb_ff, o_re_ff, o_cnt_ff;
   logic [HitOutWidth-1:0] o_hn_ff;
   logic [FieldWidth-1:0]  o_st_ff;
   logic [StatusWidth-1:0] o_status_ff;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign go_right = strict_ff ? (rd_start_ff <= key_ff) : (rd_start_ff < key_ff);

   assign sts.search_done  = !pend_ff && (lo_ff == hi_ff);
   assign sts.shift_done   = (k_ff == lo_ff);
   assign sts.needs_insert = (op_ff == OP_ADD) && disc_ff && !full_ff && !exh_ff;

   // Single read port shared by search probes, shift moves and entry reads.
   logic [AW-1:0] rd_addr;
   always_comb begin
      if (cmd.shift_step) rd_addr = AW'(k_ff - CW'(1));
      else if (cmd.load)  rd_addr = AW'(req_entry_index);
      else                rd_addr = mid[AW-1:0];
   end

   always_ff @(posedge clock) begin
      rd_start_ff <= start_mem[rd_addr];
      rd_hit_ff   <= hit_mem[rd_addr];
   end

   // Shift writes entry k-1 (read last cycle) into slot k.
   logic shift_wr_ff;
   always_ff @(posedge clock) begin
      if (reset) shift_wr_ff <= 1'b0;
      else       shift_wr_ff <= cmd.shift_step;
   end

   logic [CW-1:0] wr_k_ff;
   always_ff @(posedge clock) begin
      wr_k_ff <= k_ff;
      if (shift_wr_ff) begin
         start_mem[wr_k_ff[AW-1:0]] <= rd_start_ff;
         hit_mem[wr_k_ff[AW-1:0]]   <= rd_hit_ff;
      end else if (cmd.insert) begin
         start_mem[lo_ff[AW-1:0]] <= key_ff;
         hit_mem[lo_ff[AW-1:0]]   <= hn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         next_hit_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         next_hit_ff <= next_hit_in;
         if (cmd.load || cmd.search_lo) pend_ff <= 1'b0;
         else if (cmd.search_step)      pend_ff <= !pend_ff;
      end
   end

   always_comb begin
      count_in    = count_ff;
      next_hit_in = next_hit_ff;
      if (cmd.load && req_operation == OP_CLEAR) begin
         count_in    = '0;
         next_hit_in = '0;
      end else if (cmd.load && req_operation == OP_ADD
                   && next_hit_ff < NW'(MAX_HITS)) begin
         next_hit_in = next_hit_ff + NW'(1);
      end else if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         lo_key_ff <= req_start_pos[POS_WIDTH-1:0];
         key_ff    <= (req_operation == OP_QUERY) ? req_stop_pos[POS_WIDTH-1:0]
                                                  : req_start_pos[POS_WIDTH-1:0];
         strict_ff <= 1'b1;
         disc_ff   <= req_is_discontiguous;
         idx_ff    <= req_entry_index;
         lo_ff     <= '0;
         hi_ff     <= count_ff;
         k_ff      <= count_ff;
         exh_ff    <= (next_hit_ff >= NW'(MAX_HITS));
         full_ff   <= (count_ff >= CW'(TABLE_DEPTH));
         hn_ff     <= HW'(next_hit_ff);
      end else if (cmd.search_lo) begin
         upper_ff  <= lo_ff;
         key_ff    <= lo_key_ff;
         strict_ff <= 1'b0;
         lo_ff     <= '0;
         hi_ff     <= count_ff;
      end else if (cmd.search_step && pend_ff) begin
         if (go_right) lo_ff <= mid + CW'(1);
         else          hi_ff <= mid;
      end else if (cmd.shift_step) begin
         k_ff <= k_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         o_rb_ff     <= '0;
         o_re_ff     <= '0;
         o_hn_ff     <= '0;
         o_st_ff     <= '0;
         o_status_ff <= ST_OK;
         o_cnt_ff    <= PosOutWidth'(count_ff);
         case (op_ff)
            OP_ADD: begin
               if (exh_ff) o_status_ff <= ST_EXHAUSTED;
               else begin
                  o_hn_ff <= HitOutWidth'(hn_ff);
                  o_st_ff <= FieldWidth'(lo_key_ff);
                  if (disc_ff && full_ff) o_status_ff <= ST_FULL;
               end
            end
            OP_QUERY: begin
               o_rb_ff <= PosOutWidth'(lo_ff);
               o_re_ff <= (upper_ff < lo_ff) ? PosOutWidth'(lo_ff)
                                             : PosOutWidth'(upper_ff);
            end
            OP_READ: begin
               if (IW'(idx_ff) >= IW'(count_ff)) o_status_ff <= ST_BAD_INDEX;
               else begin
                  o_hn_ff <= HitOutWidth'(rd_hit_ff);
                  o_st_ff <= FieldWidth'(rd_start_ff);
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_range_begin      = o_rb_ff;
   assign rsp_range_end        = o_re_ff;
   assign rsp_entry_hit_number = o_hn_ff;
   assign rsp_entry_start      = o_st_ff;
   assign rsp_entry_count      = o_cnt_ff;
   assign rsp_status           = o_status_ff;

endmodule

>>> rtl/core/sorted_start_index_range_query_unit.sv
// ----------------------------------------------------------------------------
// Sorted start index range query unit
// Sorted (start, hit number) table with add, range query and entry read.
// ----------------------------------------------------------------------------
// One request at a time. A range query runs two binary searches through the
// single table read port; an add runs one search and then, for an entry that
// is stored in the table, moves every entry above the insertion point up by
// one, one entry a cycle. The response is held until it is transferred; the
// next request is taken after that.
module sorted_start_index_range_query_unit #(
   parameter int TABLE_DEPTH = ssirq_pkg::TableDepthDefault,
   parameter int MAX_HITS    = ssirq_pkg::MaxHitsDefault,
   parameter int POS_WIDTH   = ssirq_pkg::PosWidthDefault
) (
   input logic        clock,
   input logic        reset,
   ssirq_req_if.sink  req,
   ssirq_rsp_if.source rsp
);
   import ssirq_pkg::*;

   ssirq_cmd_type cmd;
   ssirq_sts_type sts;
   logic          busy;
   logic          req_fire;

   assign req.ready = !busy;
   assign req_fire  = req.valid && !busy;

   ssirq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_op    (req.operation),
      .rsp_taken (rsp.valid && rsp.ready),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp.valid)
   );

   ssirq_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_HITS    (MAX_HITS),
      .POS_WIDTH   (POS_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_operation        (req.operation),
      .req_start_pos        (req.start_pos),
      .req_stop_pos         (req.stop_pos),
      .req_is_discontiguous (req.is_discontiguous),
      .req_entry_index      (req.entry_index),
      .rsp_range_begin      (rsp.range_begin),
      .rsp_range_end        (rsp.range_end),
      .rsp_entry_hit_number (rsp.entry_hit_number),
      .rsp_entry_start      (rsp.entry_start),
      .rsp_entry_count      (rsp.entry_count),
      .rsp_status           (rsp.status)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.search_step, cmd.search_lo, cmd.shift_step,
                cmd.insert, cmd.finish}))
      else $error("more than one datapath command at once");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while a response waits");

   a_finish_then_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp.valid)
      else $error("response not presented after it was formed");

endmodule

>>> sim/tb_sorted_start_index_range_query_unit.sv
// ----------------------------------------------------------------------------
// Sorted start index range query unit testbench
// Drives clear, add, range query and read requests with random gaps and
// checks every response against a behavioral model of the sorted hit table.
// ----------------------------------------------------------------------------
module tb_sorted_start_index_range_query_unit;
   import ssirq_pkg::*;

   localparam int Depth   = 256;
   localparam int MaxHits = 1024;
   localparam int CycleLimit = 1500000;

   typedef struct packed {
      logic [OpWidth-1:0]    operation;
      logic [FieldWidth-1:0] start_pos;
      logic [FieldWidth-1:0] stop_pos;
      logic                  is_discontiguous;
      logic [IndexWidth-1:0] entry_index;
   } request_type;

   typedef struct packed {
      logic [PosOutWidth-1:0] range_begin;
      logic [PosOutWidth-1:0] range_end;
      logic [HitOutWidth-1:0] entry_hit_number;
      logic [FieldWidth-1:0]  entry_start;
      logic [PosOutWidth-1:0] entry_count;
      logic [StatusWidth-1:0] status;
   } response_type;

   logic clock;
   logic reset;

   ssirq_req_if req_if ();
   ssirq_rsp_if rsp_if ();

   sorted_start_index_range_query_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   // Model of the hit table.
   logic [15:0] table_starts [Depth];
   logic [9:0]  table_hits [Depth];
   int          table_count;
   int          hit_counter;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int        error_count;
   int        cycle_count;
   int        driver_gap;
   int        monitor_gap;
   int        hold_off;
   bit        stimulus_done;
   int        responses_seen;
   int        op_seen[4];
   int        status_seen[4];

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int first_above_key(input logic [15:0] key, input bit inclusive);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = table_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (inclusive ? (table_starts[mid] <= key) : (table_starts[mid] < key))
            lo = mid + 1;
         else
            hi = mid;
      end
      return lo;
   endfunction

   function automatic response_type table_apply(input request_type r);
      response_type res;
      int pos;
      res = '0;
      case (r.operation)
         OP_CLEAR: begin
            table_count = 0;
            hit_counter = 0;
         end
         OP_ADD: begin
            if (hit_counter >= MaxHits) begin
               res.status = ST_EXHAUSTED;
            end else begin
               res.entry_hit_number = hit_counter[9:0];
               res.entry_start = r.start_pos;
               if (r.is_discontiguous) begin
                  if (table_count >= Depth) begin
                     res.status = ST_FULL;
                  end else begin
                     pos = first_above_key(r.start_pos, 1'b1);
                     for (int k = table_count; k > pos; k--) begin
                        table_starts[k] = table_starts[k-1];
                        table_hits[k] = table_hits[k-1];
                     end
                     table_starts[pos] = r.start_pos;
                     table_hits[pos] = hit_counter[9:0];
                     table_count++;
                  end
               end
               hit_counter++;
            end
         end
         OP_QUERY: begin
            res.range_begin = 9'(first_above_key(r.start_pos, 1'b0));
            res.range_end = 9'(first_above_key(r.stop_pos, 1'b1));
            if (res.range_end < res.range_begin) res.range_end = res.range_begin;
         end
         default: begin
            if (int'(r.entry_index) >= table_count) begin
               res.status = ST_BAD_INDEX;
            end else begin
               res.entry_hit_number = table_hits[r.entry_index];
               res.entry_start = table_starts[r.entry_index];
            end
         end
      endcase
      res.entry_count = table_count[8:0];
      return res;
   endfunction

   function automatic request_type make_request(input logic [1:0] op, input logic [15:0] a,
                                                input logic [15:0] b, input logic d,
                                                input logic [7:0] idx);
      request_type r;
      r.operation = op;
      r.start_pos = a;
      r.stop_pos = b;
      r.is_discontiguous = d;
      r.entry_index = idx;
      return r;
   endfunction

   function automatic logic [15:0] random_position();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return 16'($urandom_range(0, 40));
      if (sel < 7) return 16'($urandom_range(65500, 65535));
      return 16'($urandom);
   endfunction

   function automatic request_type random_request();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 2)
         return make_request(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom),
                             8'($urandom));
      if (sel < 50)
         return make_request(OP_ADD, random_position(), 16'($urandom),
                             ($urandom_range(0, 4) != 0), 8'($urandom));
      if (sel < 75)
         return make_request(OP_QUERY, random_position(), random_position(), 1'($urandom),
                             8'($urandom));
      return make_request(OP_READ, 16'($urandom), 16'($urandom), 1'($urandom),
                          8'($urandom_range(0, 40)));
   endfunction

   function automatic int random_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: offers pending items, idling between them at random.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         driver_gap <= 0;
      end else if (req_if.valid && !req_if.ready) begin
         // Hold the current item until it is transferred.
      end else if (driver_gap > 0) begin
         req_if.valid <= 1'b0;
         driver_gap <= driver_gap - 1;
      end else if (pending_requests.size() > 0) begin
         request_type r;
         r = pending_requests.pop_front();
         req_if.valid <= 1'b1;
         req_if.operation <= r.operation;
         req_if.start_pos <= r.start_pos;
         req_if.stop_pos <= r.stop_pos;
         req_if.is_discontiguous <= r.is_discontiguous;
         req_if.entry_index <= r.entry_index;
         driver_gap <= random_gap();
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // The prediction is made when a request transfer is seen.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         request_type r;
         r = make_request(req_if.operation, req_if.start_pos, req_if.stop_pos,
                          req_if.is_discontiguous, req_if.entry_index);
         op_seen[r.operation]++;
         expected_responses.push_back(table_apply(r));
      end
   end

   // Monitor: checks response transfers and stalls the response side at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         monitor_gap <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            response_type exp;
            responses_seen++;
            if (expected_responses.size() == 0) begin
               $error("response with nothing expected");
               error_count++;
            end else begin
               exp = expected_responses.pop_front();
               status_seen[exp.status]++;
               if (rsp_if.range_begin !== exp.range_begin) begin
                  $error("range_begin: expected %0d, got %0d", exp.range_begin,
                         rsp_if.range_begin);
                  error_count++;
               end
               if (rsp_if.range_end !== exp.range_end) begin
                  $error("range_end: expected %0d, got %0d", exp.range_end,
                         rsp_if.range_end);
                  error_count++;
               end
               if (rsp_if.entry_hit_number !== exp.entry_hit_number) begin
                  $error("entry_hit_number: expected %0d, got %0d", exp.entry_hit_number,
                         rsp_if.entry_hit_number);
                  error_count++;
               end
               if (rsp_if.entry_start !== exp.entry_start) begin
                  $error("entry_start: expected %0d, got %0d", exp.entry_start,
                         rsp_if.entry_start);
                  error_count++;
               end
               if (rsp_if.entry_count !== exp.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", exp.entry_count,
                         rsp_if.entry_count);
                  error_count++;
               end
               if (rsp_if.status !== exp.status) begin
                  $error("status: expected %0d, got %0d", exp.status, rsp_if.status);
                  error_count++;
               end
            end
         end
         if (hold_off > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off <= hold_off - 1;
         end else if (monitor_gap > 0) begin
            rsp_if.ready <= 1'b0;
            monitor_gap <= monitor_gap - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            monitor_gap <= random_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_sorted_start_index_range_query_unit: FAIL");
         $finish;
      end
   end

   initial begin
      int long_stall_at;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.operation = OP_CLEAR;
      req_if.start_pos = '0;
      req_if.stop_pos = '0;
      req_if.is_discontiguous = 1'b0;
      req_if.entry_index = '0;
      rsp_if.ready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      hold_off = 0;
      responses_seen = 0;
      table_count = 0;
      hit_counter = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, extremes, ties, inverted range, bad index.
      pending_requests.push_back(make_request(OP_QUERY, 16'h0000, 16'hFFFF, 1'b0, 8'h00));
      pending_requests.push_back(make_request(OP_READ, 16'h0000, 16'h0000, 1'b0, 8'h00));
      pending_requests.push_back(make_request(OP_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF));
      pending_requests.push_back(make_request(OP_ADD, 16'h0000, 16'h0000, 1'b1, 8'h00));
      pending_requests.push_back(make_request(OP_ADD, 16'h0005, 16'h0000, 1'b1, 8'h00));
      pending_requests.push_back(make_request(OP_ADD, 16'h0005, 16'h0000, 1'b1, 8'h00));
      pending_requests.push_back(make_request(OP_ADD, 16'h0005, 16'h0000, 1'b0, 8'h00));
      pending_requests.push_back(make_request(OP_QUERY, 16'h0005, 16'h0005, 1'b0, 8'h00));
      pending_requests.push_back(make_request(OP_QUERY, 16'h0009, 16'h0001, 1'b0, 8'h00));
      pending_requests.push_back(make_request(OP_QUERY, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF));
      pending_requests.push_back(make_request(OP_READ, 16'hFFFF, 16'hFFFF, 1'b1, 8'h01));
      pending_requests.push_back(make_request(OP_READ, 16'h0000, 16'h0000, 1'b0, 8'h02));
      pending_requests.push_back(make_request(OP_READ, 16'h0000, 16'h0000, 1'b0, 8'h04));
      pending_requests.push_back(make_request(OP_READ, 16'h0000, 16'h0000, 1'b0, 8'hFF));
      pending_requests.push_back(make_request(OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF));
      pending_requests.push_back(make_request(OP_READ, 16'h0000, 16'h0000, 1'b0, 8'h00));

      // Fill the table completely, then check the full status.
      for (int i = 0; i < Depth + 4; i++)
         pending_requests.push_back(make_request(OP_ADD, 16'($urandom_range(0, 300)),
                                                 16'($urandom), 1'b1, 8'($urandom)));
      pending_requests.push_back(make_request(OP_READ, 16'h0, 16'h0, 1'b0, 8'hFF));
      pending_requests.push_back(make_request(OP_QUERY, 16'd100, 16'd200, 1'b0, 8'h0));
      pending_requests.push_back(make_request(OP_ADD, 16'h1234, 16'h0, 1'b1, 8'h0));
      pending_requests.push_back(make_request(OP_ADD, 16'h1234, 16'h0, 1'b0, 8'h0));
      pending_requests.push_back(make_request(OP_CLEAR, 16'h0, 16'h0, 1'b0, 8'h0));

      // Random part.
      for (int i = 0; i < 270; i++)
         pending_requests.push_back(random_request());

      // A long receiver hold-off while the sender keeps offering items.
      long_stall_at = $urandom_range(100, 400);
      while (responses_seen < long_stall_at) @(posedge clock);
      hold_off <= 300;

      while (pending_requests.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_responses.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (rsp_if.valid) begin
         $error("response with nothing expected");
         error_count++;
      end

      $display("covered %0d clears, %0d adds, %0d queries, %0d reads", op_seen[OP_CLEAR],
               op_seen[OP_ADD], op_seen[OP_QUERY], op_seen[OP_READ]);
      $display("statuses ok %0d, full %0d, bad index %0d, exhausted %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD_INDEX],
               status_seen[ST_EXHAUSTED]);
      if (error_count == 0)
         $display("tb_sorted_start_index_range_query_unit: PASS");
      else
         $display("tb_sorted_start_index_range_query_unit: FAIL");
      $finish;
   end

endmodule
